/* rtl/core/swfe_pkg.sv */
// ----------------------------------------------------------------------------
// swfe_pkg: shared types and constants for the shallow water flux evaluator
// Field widths, mode codes, register indexes and the stage-to-stage records.
// ----------------------------------------------------------------------------
`default_nettype none
package swfe_pkg;

  localparam int WordBits = 32;
  localparam int FracBits = 16;
  localparam int MagBits  = WordBits;            // magnitude of a word (2^31 fits)
  localparam int ProdBits = 2 * MagBits;         // magnitude of a product
  localparam int DivSteps = ProdBits;            // one quotient bit per stage
  localparam int QuoBits  = ProdBits;

  typedef logic signed [WordBits-1:0] word_t;
  typedef logic [MagBits-1:0]         mag_t;
  typedef logic [ProdBits-1:0]        prod_t;

  typedef enum logic [1:0] {
    MODE_TRANSPORT = 2'd0,
    MODE_NONLINEAR = 2'd1,
    MODE_LINEAR    = 2'd2,
    MODE_UNUSED    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_COEFF1 = 2'd1,
    REG_COEFF2 = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  // Record for one divide lane (dividend magnitude and sign).
  typedef struct packed {
    prod_t num;
    logic  neg;
  } div_lane_t;

  // Side data that rides alongside the dividers.
  typedef struct packed {
    mode_t      mode;
    logic       bad;
    word_t      f0;
    word_t      f1;
    logic       pneg;      // sign of pressure / linear / first transport term
    logic [95:0] pmag;     // unshifted |triple product| (c1*H in transport)
  } side_t;

  // Magnitude of a word.
  function automatic mag_t mag_of(input word_t v);
    mag_t r;
    r = v[WordBits-1] ? mag_t'(-v) : mag_t'(v);
    return r;
  endfunction

  // Saturate a sign-magnitude value (up to 128 bits) to a word.
  function automatic logic [WordBits:0] sat(input logic neg, input logic [127:0] m);
    logic [127:0] lim;
    logic [WordBits-1:0] w;
    logic c;
    lim = neg ? (128'(1) << (WordBits-1)) : ((128'(1) << (WordBits-1)) - 128'(1));
    c = m > lim;
    w = c ? lim[WordBits-1:0] : m[WordBits-1:0];
    w = neg ? -w : w;
    return {c, w};
  endfunction

endpackage
`default_nettype wire

/* rtl/core/swfe_div_stage.sv */
// ----------------------------------------------------------------------------
// swfe_div_stage: one restoring divide step for three lanes sharing a divisor
// Each stage settles one quotient bit per lane, registered, with stall hold.
// ----------------------------------------------------------------------------
`default_nettype none
module swfe_div_stage (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  adv,
  input  wire logic                  in_vld,
  input  wire swfe_pkg::prod_t       in_rem   [3],
  input  wire swfe_pkg::prod_t       in_quo   [3],
  input  wire swfe_pkg::prod_t       in_num   [3],
  input  wire swfe_pkg::mag_t        in_den,
  input  wire swfe_pkg::side_t       in_side,
  output logic                       out_vld,
  output swfe_pkg::prod_t            out_rem  [3],
  output swfe_pkg::prod_t            out_quo  [3],
  output swfe_pkg::prod_t            out_num  [3],
  output swfe_pkg::mag_t             out_den,
  output swfe_pkg::side_t            out_side
);
  import swfe_pkg::*;

  prod_t rem_nxt [3];
  prod_t quo_nxt [3];
  prod_t num_nxt [3];
  logic [ProdBits:0] t;

  // shift in next dividend bit, subtract when it fits
  always_comb begin
    t = '0;
    for (int i = 0; i < 3; i++) begin
      t = {in_rem[i], in_num[i][ProdBits-1]};
      num_nxt[i] = {in_num[i][ProdBits-2:0], 1'b0};
      if (t >= {1'b0, {MagBits{1'b0}}, in_den}) begin
        rem_nxt[i] = prod_t'(t - {1'b0, {MagBits{1'b0}}, in_den});
        quo_nxt[i] = {in_quo[i][ProdBits-2:0], 1'b1};
      end else begin
        rem_nxt[i] = t[ProdBits-1:0];
        quo_nxt[i] = {in_quo[i][ProdBits-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rem  <= rem_nxt;
      out_quo  <= quo_nxt;
      out_num  <= num_nxt;
      out_den  <= in_den;
      out_side <= in_side;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/shallow_water_flux_eval_core.sv */
// Pipeline: front multiply stages, one restoring divider stage per quotient
//   bit (a 64-stage chain that sets depth), one saturate/output stage.
// Throughput: one beat per cycle unless a stalled output holds the pipeline.
// A stall freezes the whole pipeline; no beat is lost or repeated.
// Reset (rst_n low, synchronous) clears valid bits and sets mode nonlinear,
//   g = 642908, h0 = 65536.
// ----------------------------------------------------------------------------
// shallow_water_flux_eval_core: shallow water physical flux pipeline
// Products, pipelined divide of the advective terms, saturation and flags.
// ----------------------------------------------------------------------------
`default_nettype none
module shallow_water_flux_eval_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire swfe_pkg::word_t     in_height,
  input  wire swfe_pkg::word_t     in_mom_x,
  input  wire swfe_pkg::word_t     in_mom_y,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output swfe_pkg::word_t          out_fx_mass,
  output swfe_pkg::word_t          out_fy_mass,
  output swfe_pkg::word_t          out_fx_xmom,
  output swfe_pkg::word_t          out_fx_ymom,
  output swfe_pkg::word_t          out_fy_xmom,
  output swfe_pkg::word_t          out_fy_ymom,
  output logic                     out_bad_height,
  output logic                     out_clipped,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import swfe_pkg::*;

  // ---------------- configuration registers ----------------
  mode_t mode_r;
  word_t c1_r, c2_r;
  reg_idx_t widx;
  assign widx = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NONLINEAR;
      c1_r   <= word_t'(642908);
      c2_r   <= word_t'(65536);
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_MODE:   mode_r <= mode_t'(pwdata[1:0]);
        REG_COEFF1: c1_r   <= pwdata;
        REG_COEFF2: c2_r   <= pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_MODE:   prdata = {30'd0, mode_r};
      REG_COEFF1: prdata = c1_r;
      REG_COEFF2: prdata = c2_r;
      default:    prdata = '0;
    endcase
  end

  // global advance: output register free or draining
  logic adv;
  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  // ---------------- stage A: register inputs, magnitudes ----------------
  logic  a_vld_r;
  mode_t a_mode_r;
  word_t a_h_r, a_u_r, a_v_r;
  mag_t  a_hm_r, a_um_r, a_vm_r, a_c1m_r, a_c2m_r;
  logic  a_c1n_r, a_c2n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (adv) a_vld_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      a_mode_r <= mode_r;
      a_h_r <= in_height; a_u_r <= in_mom_x; a_v_r <= in_mom_y;
      a_hm_r <= mag_of(in_height); a_um_r <= mag_of(in_mom_x);
      a_vm_r <= mag_of(in_mom_y);
      a_c1m_r <= mag_of(c1_r); a_c2m_r <= mag_of(c2_r);
      a_c1n_r <= c1_r[WordBits-1]; a_c2n_r <= c2_r[WordBits-1];
    end
  end

  // ---------------- stage B: 32x32 products ----------------
  logic  b_vld_r;
  mode_t b_mode_r;
  word_t b_h_r, b_u_r, b_v_r;
  prod_t b_uu_r, b_vv_r, b_uv_r, b_k_r, b_t2_r;
  mag_t  b_hm_r;
  logic  b_kn_r, b_t2n_r;
  prod_t k_nxt;
  logic  kn_nxt;

  // nonlinear: g*H, transport: c1*H, linear: g*h0
  always_comb begin
    if (a_mode_r == MODE_LINEAR) begin
      k_nxt  = prod_t'(a_c1m_r) * prod_t'(a_c2m_r);
      kn_nxt = a_c1n_r ^ a_c2n_r;
    end else begin
      k_nxt  = prod_t'(a_c1m_r) * prod_t'(a_hm_r);
      kn_nxt = a_c1n_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else if (adv) b_vld_r <= a_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      b_mode_r <= a_mode_r;
      b_h_r <= a_h_r; b_u_r <= a_u_r; b_v_r <= a_v_r;
      b_hm_r <= a_hm_r;
      b_uu_r <= prod_t'(a_um_r) * prod_t'(a_um_r);
      b_vv_r <= prod_t'(a_vm_r) * prod_t'(a_vm_r);
      b_uv_r <= prod_t'(a_um_r) * prod_t'(a_vm_r);
      b_k_r  <= k_nxt;
      b_kn_r <= kn_nxt;
      // transport second term a_y*H
      b_t2_r  <= prod_t'(a_c2m_r) * prod_t'(a_hm_r);
      b_t2n_r <= a_c2n_r ^ a_h_r[WordBits-1];
    end
  end

  // ---------------- stage C: triple product (split 64x32) ----------------
  logic  c_vld_r;
  side_t c_side;
  prod_t c_num [3];
  prod_t zero3 [3];
  logic [95:0] p_nxt;
  logic [95:0] c_pmag_r;
  logic  c_pneg_r, c_bad_r;
  mode_t c_mode_r;
  word_t c_f0_r, c_f1_r;
  prod_t c_uu_r, c_vv_r, c_uv_r;
  mag_t  c_den_r;
  logic  c_qneg_r;
  logic  hpos;
  prod_t lo_p, hi_p;

  assign hpos = !b_h_r[WordBits-1] && (b_h_r != '0);
  assign lo_p = prod_t'(b_k_r[31:0]) * prod_t'(b_hm_r);
  assign hi_p = prod_t'(b_k_r[63:32]) * prod_t'(b_hm_r);

  always_comb begin
    if (b_mode_r == MODE_TRANSPORT) p_nxt = {32'd0, b_k_r};
    else p_nxt = {32'd0, lo_p} + {hi_p, 32'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r <= 1'b0;
    else if (adv) c_vld_r <= b_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      c_mode_r <= b_mode_r;
      c_bad_r  <= (b_mode_r == MODE_NONLINEAR) && !hpos;
      c_pmag_r <= p_nxt;
      c_pneg_r <= (b_mode_r == MODE_LINEAR) ? (b_kn_r ^ b_h_r[WordBits-1]) :
                  (b_mode_r == MODE_TRANSPORT) ? (b_kn_r ^ b_h_r[WordBits-1]) : b_kn_r;
      if (b_mode_r == MODE_TRANSPORT) begin
        c_f0_r <= '0; c_f1_r <= '0;
        c_uu_r <= b_t2_r; c_vv_r <= '0; c_uv_r <= '0;
        c_qneg_r <= b_t2n_r;
      end else begin
        c_f0_r <= b_u_r; c_f1_r <= b_v_r;
        c_uu_r <= hpos ? b_uu_r : '0;
        c_vv_r <= hpos ? b_vv_r : '0;
        c_uv_r <= hpos ? b_uv_r : '0;
        c_qneg_r <= b_u_r[WordBits-1] ^ b_v_r[WordBits-1];
      end
      // divide by 1 unless height > 0 (quotients only used in nonlinear mode)
      c_den_r <= hpos ? b_hm_r : mag_t'(1);
    end
  end

  assign c_num[0] = c_uu_r;
  assign c_num[1] = c_vv_r;
  assign c_num[2] = c_uv_r;
  assign zero3[0] = '0; assign zero3[1] = '0; assign zero3[2] = '0;

  always_comb begin
    c_side.mode = c_mode_r;
    c_side.bad  = c_bad_r;
    c_side.f0   = c_f0_r;
    c_side.f1   = c_f1_r;
    c_side.pneg = c_pneg_r;
    c_side.pmag = c_pmag_r;
  end

  // qneg and transport second term magnitude ride a divider-length delay line
  logic [DivSteps-1:0] qn_r;
  prod_t t2_keep_r [DivSteps];
  always_ff @(posedge clk) begin
    if (adv) begin
      qn_r[0] <= c_qneg_r;
      t2_keep_r[0] <= c_uu_r;
      for (int i = 1; i < DivSteps; i++) begin
        qn_r[i] <= qn_r[i-1];
        t2_keep_r[i] <= t2_keep_r[i-1];
      end
    end
  end

  // ---------------- divider chain ----------------
  logic  d_vld [DivSteps+1];
  prod_t d_rem [DivSteps+1][3];
  prod_t d_quo [DivSteps+1][3];
  prod_t d_num [DivSteps+1][3];
  mag_t  d_den [DivSteps+1];
  side_t d_side[DivSteps+1];

  assign d_vld[0]  = c_vld_r;
  assign d_rem[0]  = zero3;
  assign d_quo[0]  = zero3;
  assign d_num[0]  = c_num;
  assign d_den[0]  = c_den_r;
  assign d_side[0] = c_side;

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    swfe_div_stage u_stage (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .in_vld(d_vld[g]), .in_rem(d_rem[g]), .in_quo(d_quo[g]),
      .in_num(d_num[g]), .in_den(d_den[g]), .in_side(d_side[g]),
      .out_vld(d_vld[g+1]), .out_rem(d_rem[g+1]), .out_quo(d_quo[g+1]),
      .out_num(d_num[g+1]), .out_den(d_den[g+1]), .out_side(d_side[g+1])
    );
  end

  // ---------------- final stage: combine, saturate ----------------
  side_t fs;
  prod_t qxx, qyy, qxy, t2m;
  logic  qn;
  logic [127:0] pm;
  logic [127:0] sxx, syy;
  logic nxx, nyy;
  logic [WordBits:0] s0, s1, s2, s3, s4, s5;
  logic bad_nxt;

  assign fs  = d_side[DivSteps];
  assign qxx = d_quo[DivSteps][0];
  assign qyy = d_quo[DivSteps][1];
  assign qxy = d_quo[DivSteps][2];
  assign qn  = qn_r[DivSteps-1];
  assign t2m = t2_keep_r[DivSteps-1];

  always_comb begin
    pm = '0; sxx = '0; syy = '0; nxx = 1'b0; nyy = 1'b0;
    s0 = '0; s1 = '0; s2 = '0; s3 = '0; s4 = '0; s5 = '0;
    bad_nxt = 1'b0;
    case (fs.mode)
      MODE_TRANSPORT: begin
        s0 = sat(fs.pneg, 128'(fs.pmag >> FracBits));
        s1 = sat(qn, 128'(t2m >> FracBits));
      end
      MODE_NONLINEAR: begin
        pm = 128'(fs.pmag >> (2*FracBits+1));
        s0 = sat(fs.f0[WordBits-1], 128'(mag_of(fs.f0)));
        s1 = sat(fs.f1[WordBits-1], 128'(mag_of(fs.f1)));
        // quotient is nonnegative; add signed pressure
        if (!fs.pneg) begin
          sxx = 128'(qxx) + pm; nxx = 1'b0;
          syy = 128'(qyy) + pm; nyy = 1'b0;
        end else begin
          nxx = pm > 128'(qxx);
          sxx = nxx ? pm - 128'(qxx) : 128'(qxx) - pm;
          nyy = pm > 128'(qyy);
          syy = nyy ? pm - 128'(qyy) : 128'(qyy) - pm;
        end
        s2 = sat(nxx, sxx);
        s5 = sat(nyy, syy);
        s3 = sat(qn && (qxy != '0), 128'(qxy));
        s4 = s3;
        bad_nxt = fs.bad;
      end
      MODE_LINEAR: begin
        s0 = sat(fs.f0[WordBits-1], 128'(mag_of(fs.f0)));
        s1 = sat(fs.f1[WordBits-1], 128'(mag_of(fs.f1)));
        s2 = sat(fs.pneg, 128'(fs.pmag >> (2*FracBits)));
        s5 = s2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (adv) out_valid <= d_vld[DivSteps];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_fx_mass <= s0[WordBits-1:0];
      out_fy_mass <= s1[WordBits-1:0];
      out_fx_xmom <= s2[WordBits-1:0];
      out_fx_ymom <= s3[WordBits-1:0];
      out_fy_xmom <= s4[WordBits-1:0];
      out_fy_ymom <= s5[WordBits-1:0];
      out_bad_height <= bad_nxt;
      out_clipped <= s0[WordBits] | s1[WordBits] | s2[WordBits] |
                     s3[WordBits] | s4[WordBits] | s5[WordBits];
    end
  end

  // ---------------- assertions ----------------
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_fx_xmom))
    else $error("result changed under stall");
  a_stall_is_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");
  a_bad_mode: assert property (@(posedge clk) disable iff (!rst_n)
    fs.bad |-> fs.mode == MODE_NONLINEAR)
    else $error("bad height outside nonlinear mode");
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    c_vld_r |-> c_den_r != '0)
    else $error("zero divisor entered divider");

endmodule
`default_nettype wire

/* verif/tb_shallow_water_flux_eval_core.sv */
// ----------------------------------------------------------------------------
// tb_shallow_water_flux_eval_core: self-checking bench for the flux pipeline
// A directed table and then random node states in all four modes. Each input
// beat without a typed result is predicted with exact wide arithmetic, and
// the expectations are compared in order with the result beats. The sender
// works in bursts, the receiver stalls on its own pattern, and registers are
// written over APB only while the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_shallow_water_flux_eval_core;
  import swfe_pkg::*;

  localparam word_t ONE   = 32'sd65536;
  localparam word_t WMAX  = 32'sh7fffffff;
  localparam word_t WMIN  = 32'sh80000000;
  localparam word_t G_RST = 32'sd642908;
  localparam int    DRAIN_CYCLES = 80;     // pipeline depth is 68
  localparam int    IDLE_LIMIT   = 3000;
  localparam int    PHASES       = 8;
  localparam int    PHASE_ITEMS  = 55;

  typedef struct {
    word_t fx_mass, fy_mass, fx_xmom, fx_ymom, fy_xmom, fy_ymom;
    logic  bad, clip;
  } flux_t;

  typedef struct {
    mode_t mode;
    word_t c1, c2, h, u, v;
    bit    known;
    flux_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  word_t in_height = '0, in_mom_x = '0, in_mom_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  word_t out_fx_mass, out_fy_mass, out_fx_xmom, out_fx_ymom, out_fy_xmom, out_fy_ymom;
  logic out_bad_height, out_clipped;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Register shadow
  mode_t cfg_mode = MODE_NONLINEAR;
  word_t cfg_c1 = G_RST, cfg_c2 = ONE;

  // Typed expectation riding with the beat on the input port
  bit    drv_known = 1'b0;
  flux_t drv_res;

  flux_t flux_expect_q[$];
  int    err_cnt = 0;
  int    idle_cycles = 0;
  int    burst_left = 0;
  bit    hold_go = 1'b0;

  shallow_water_flux_eval_core DUT (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_height, .in_mom_x, .in_mom_y,
    .out_valid, .out_stall,
    .out_fx_mass, .out_fy_mass, .out_fx_xmom, .out_fx_ymom, .out_fy_xmom, .out_fy_ymom,
    .out_bad_height, .out_clipped,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #10 clk = ~clk;

  // ---------------- flux prediction ----------------
  function automatic logic [127:0] mag128(input word_t x);
    logic [31:0] t;
    t = x;
    if (t[31]) t = ~t + 32'd1;
    return {96'd0, t};
  endfunction

  function automatic logic signed [129:0] signed_of(input logic neg, input logic [127:0] m);
    logic signed [129:0] s;
    s = $signed({2'b00, m});
    return neg ? -s : s;
  endfunction

  function automatic word_t clamp_word(input logic signed [129:0] x, inout logic clip);
    logic signed [129:0] hi, lo;
    hi = 130'sd2147483647;
    lo = -130'sd2147483648;
    if (x > hi) begin
      clip = 1'b1;
      return WMAX;
    end
    if (x < lo) begin
      clip = 1'b1;
      return WMIN;
    end
    return word_t'(x[31:0]);
  endfunction

  function automatic flux_t predict_flux(input mode_t mode, input word_t c1, input word_t c2,
                                         input word_t h, input word_t u, input word_t v);
    logic [127:0] mh, mu, mv, m1, m2;
    logic signed [129:0] f0, f1, f2, f3, f5, press;
    logic clip;
    flux_t r;
    mh = mag128(h); mu = mag128(u); mv = mag128(v);
    m1 = mag128(c1); m2 = mag128(c2);
    f0 = '0; f1 = '0; f2 = '0; f3 = '0; f5 = '0;
    clip = 1'b0;
    r.bad = 1'b0;
    case (mode)
      MODE_TRANSPORT: begin
        f0 = signed_of(c1[31] ^ h[31], (m1 * mh) >> FracBits);
        f1 = signed_of(c2[31] ^ h[31], (m2 * mh) >> FracBits);
      end
      MODE_NONLINEAR: begin
        f0 = signed_of(u[31], mu);
        f1 = signed_of(v[31], mv);
        press = signed_of(c1[31], (m1 * mh * mh) >> (2 * FracBits + 1));
        // advective quotients only exist for a positive height
        if (h > 0) begin
          f2 = signed_of(1'b0, (mu * mu) / mh) + press;
          f5 = signed_of(1'b0, (mv * mv) / mh) + press;
          f3 = signed_of(u[31] ^ v[31], (mu * mv) / mh);
        end else begin
          r.bad = 1'b1;
          f2 = press;
          f5 = press;
        end
      end
      MODE_LINEAR: begin
        f0 = signed_of(u[31], mu);
        f1 = signed_of(v[31], mv);
        f2 = signed_of(c1[31] ^ c2[31] ^ h[31], (m1 * m2 * mh) >> (2 * FracBits));
        f5 = f2;
      end
      default: ;
    endcase
    r.fx_mass = clamp_word(f0, clip);
    r.fy_mass = clamp_word(f1, clip);
    r.fx_xmom = clamp_word(f2, clip);
    r.fx_ymom = clamp_word(f3, clip);
    r.fy_xmom = clamp_word(f3, clip);
    r.fy_ymom = clamp_word(f5, clip);
    r.clip = clip;
    return r;
  endfunction

  // ---------------- monitors (sampled at the falling edge) ----------------
  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected %h, got %h", name, e, a);
      err_cnt++;
    end
  endtask

  always @(negedge clk) begin
    flux_t e;
    if (rst_n && in_valid && !in_stall)
      flux_expect_q.push_back(drv_known ? drv_res :
        predict_flux(cfg_mode, cfg_c1, cfg_c2, in_height, in_mom_x, in_mom_y));
    if (rst_n && out_valid && !out_stall) begin
      if (flux_expect_q.size() == 0) begin
        $error("result beat with no expectation pending");
        err_cnt++;
      end else begin
        e = flux_expect_q.pop_front();
        check_field("fx_mass", e.fx_mass, out_fx_mass);
        check_field("fy_mass", e.fy_mass, out_fy_mass);
        check_field("fx_xmom", e.fx_xmom, out_fx_xmom);
        check_field("fx_ymom", e.fx_ymom, out_fx_ymom);
        check_field("fy_xmom", e.fy_xmom, out_fy_xmom);
        check_field("fy_ymom", e.fy_ymom, out_fy_ymom);
        check_field("bad_height", e.bad, out_bad_height);
        check_field("clipped", e.clip, out_clipped);
      end
    end
  end

  // Watchdog: cycles with no beat on any port
  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------- receiver stall pattern ----------------
  int  stall_style = 0;
  int  style_cnt = 0;
  int  hold_cnt = 0;
  bit  hold_done = 1'b0;
  logic [2:0] phase_ctr = '0;

  always @(posedge clk) begin
    phase_ctr <= phase_ctr + 3'd1;
    if (style_cnt == 0) begin
      stall_style <= $urandom_range(0, 3);
      style_cnt <= $urandom_range(20, 100);
    end else begin
      style_cnt <= style_cnt - 1;
    end
    if (hold_go && !hold_done) begin
      // long hold-off so the pipeline fills and backs up the input
      hold_done <= 1'b1;
      hold_cnt <= 300;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (phase_ctr < 3'd3);
      endcase
    end
  end

  // ---------------- sender ----------------
  task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_MODE:   cfg_mode = mode_t'(val[1:0]);
      REG_COEFF1: cfg_c1 = val;
      REG_COEFF2: cfg_c2 = val;
      default: ;
    endcase
  endtask

  // drop valid in the same step as the last accepted beat
  task automatic wait_empty();
    in_valid <= 1'b0;
    burst_left = 0;
    while (flux_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input mode_t mode, input word_t c1, input word_t c2);
    wait_empty();
    apb_write(REG_MODE, 32'(mode));
    apb_write(REG_COEFF1, c1);
    apb_write(REG_COEFF2, c2);
  endtask

  task automatic send_node(input word_t h, input word_t u, input word_t v,
                           input bit known, input flux_t res);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_height <= h; in_mom_x <= u; in_mom_y <= v;
    drv_known <= known; drv_res <= res;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    burst_left--;
  endtask

  function automatic word_t noise_word();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $signed($urandom_range(0, 63 << 16));
      2: return -$signed($urandom_range(0, 63 << 16));
      3: begin
        case ($urandom_range(0, 4))
          0: return WMAX;
          1: return WMIN;
          2: return 32'sd0;
          3: return 32'sd1;
          default: return -32'sd1;
        endcase
      end
      default: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
    endcase
  endfunction

  function automatic word_t rnd_coeff(input int scale);
    if ($urandom_range(0, 5) == 0) return noise_word();
    return $signed($urandom_range(0, scale << 16));
  endfunction

  initial begin
    row_t rows[$];
    flux_t z;
    flux_t r;
    mode_t m;
    word_t h, u, v;
    z = '{default: '0};
    r = z;

    // directed table; typed results only where they read off at a glance
    r = z; r.bad = 1;
    rows.push_back('{MODE_NONLINEAR, G_RST, ONE, 0, 0, 0, 1, r});
    r = z; r.fx_xmom = 321454; r.fy_ymom = 321454;
    rows.push_back('{MODE_NONLINEAR, G_RST, ONE, ONE, 0, 0, 1, r});
    r.bad = 1;
    rows.push_back('{MODE_NONLINEAR, G_RST, ONE, -ONE, 0, 0, 1, r});
    r = z; r.fx_mass = WMIN; r.fx_xmom = WMAX; r.fy_ymom = 321454; r.clip = 1;
    rows.push_back('{MODE_NONLINEAR, G_RST, ONE, ONE, WMIN, 0, 1, r});
    rows.push_back('{MODE_NONLINEAR, G_RST, ONE, WMAX, WMAX, WMIN, 0, z});
    rows.push_back('{MODE_NONLINEAR, G_RST, ONE, WMIN, ONE, -ONE, 0, z});
    rows.push_back('{MODE_NONLINEAR, G_RST, ONE, ONE, 3 * ONE, -2 * ONE, 0, z});
    rows.push_back('{MODE_NONLINEAR, G_RST, ONE, 1, WMAX, WMAX, 0, z});
    rows.push_back('{MODE_NONLINEAR, WMIN, ONE, 10 * ONE, ONE, ONE, 0, z});
    rows.push_back('{MODE_NONLINEAR, WMAX, ONE, WMAX, -ONE, 5, 0, z});
    r = z; r.fx_mass = WMAX; r.fy_mass = 32'sh80000001;
    rows.push_back('{MODE_TRANSPORT, ONE, -ONE, WMAX, 0, 0, 1, r});
    r = z; r.fx_mass = WMIN; r.fy_mass = WMAX; r.clip = 1;
    rows.push_back('{MODE_TRANSPORT, ONE, -ONE, WMIN, 0, 0, 1, r});
    r = z; r.fx_mass = -ONE; r.fy_mass = ONE;
    rows.push_back('{MODE_TRANSPORT, ONE, -ONE, -ONE, WMAX, WMIN, 1, r});
    rows.push_back('{MODE_TRANSPORT, ONE, -ONE, 0, ONE, ONE, 1, z});
    rows.push_back('{MODE_LINEAR, G_RST, ONE, ONE, 5, -7, 0, z});
    rows.push_back('{MODE_LINEAR, WMAX, WMAX, WMAX, WMAX, WMIN, 0, z});
    rows.push_back('{MODE_LINEAR, WMIN, WMAX, -ONE, 1, -1, 0, z});
    r = z; r.fx_mass = WMIN; r.fy_mass = WMAX;
    rows.push_back('{MODE_LINEAR, WMIN, WMAX, 0, WMIN, WMAX, 1, r});
    rows.push_back('{MODE_UNUSED, WMIN, WMAX, ONE, ONE, ONE, 1, z});
    rows.push_back('{MODE_UNUSED, WMIN, WMAX, WMIN, WMIN, WMIN, 1, z});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    apb_write(REG_NONE, 32'hffffffff);  // no such register: ignored

    foreach (rows[i]) begin
      if (rows[i].mode != cfg_mode || rows[i].c1 != cfg_c1 || rows[i].c2 != cfg_c2)
        set_regs(rows[i].mode, rows[i].c1, rows[i].c2);
      send_node(rows[i].h, rows[i].u, rows[i].v, rows[i].known, rows[i].res);
    end

    // random phases, mostly physical states with some noise
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 6))
        0: m = MODE_TRANSPORT;
        1: m = MODE_LINEAR;
        2: m = MODE_UNUSED;
        default: m = MODE_NONLINEAR;
      endcase
      set_regs(m, rnd_coeff(20), rnd_coeff(10));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 2 && k == 5) hold_go <= 1'b1;
        if ($urandom_range(0, 9) < 7) begin
          h = $signed($urandom_range(1, 200 << 16));
          u = $signed($urandom_range(0, 100 << 16)) - (50 << 16);
          v = $signed($urandom_range(0, 100 << 16)) - (50 << 16);
        end else begin
          h = noise_word(); u = noise_word(); v = noise_word();
        end
        send_node(h, u, v, 1'b0, z);
      end
    end

    wait_empty();
    if (err_cnt == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire

/* shallow_water_flux_eval_core.f */
rtl/core/swfe_pkg.sv
rtl/core/swfe_div_stage.sv
rtl/core/shallow_water_flux_eval_core.sv
verif/tb_shallow_water_flux_eval_core.sv
